### design/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
// No dependencies; used by the candidate cell and the top level.
package swm_pkg;

   // Width of the window size register.
   localparam int CSR_WIDTH = 7;
   localparam logic [CSR_WIDTH-1:0] WINDOW_RESET = 7'd1;

   // Broadcast control from the top level to every candidate cell.
   typedef struct packed {
      logic load;   // an item is taken this cycle
      logic clear;  // item starts a new sequence
      logic shift;  // front entry leaves: every cell takes its right neighbour
   } ctrl_type;

endpackage

### design/swm_cell.sv
// One cell of the monotonic candidate queue: value, age and valid bit.
// Depends on swm_pkg for the broadcast control struct.
module swm_cell #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int AGE_W        = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_pkg::ctrl_type              ctrl,
   input  logic                           head,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           prv_keep,
   input  logic                           nxt_keep,
   input  logic signed [SAMPLE_WIDTH-1:0] nxt_value,
   input  logic [AGE_W-1:0]               nxt_age,
   output logic                           keep,
   output logic                           valid,
   output logic signed [SAMPLE_WIDTH-1:0] value,
   output logic [AGE_W-1:0]               age_inc,
   output logic signed [SAMPLE_WIDTH-1:0] value_nxt
);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic [AGE_W-1:0]               age_ff, age_in;

   // Survives the back pops only if strictly greater than the new sample.
   assign keep    = valid_ff & ~ctrl.clear & (value_ff > sample);
   assign age_inc = (&age_ff) ? age_ff : age_ff + 1'b1;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctrl.load) begin
         if (ctrl.shift) begin
            if (nxt_keep) begin
               valid_in = 1'b1;
               value_in = nxt_value;
               age_in   = nxt_age;
            end else if (head | keep) begin
               valid_in = 1'b1;
               value_in = sample;
               age_in   = '0;
            end else begin
               valid_in = 1'b0;
            end
         end else begin
            if (keep) begin
               age_in = age_inc;
            end else if (head | prv_keep) begin
               valid_in = 1'b1;
               value_in = sample;
               age_in   = '0;
            end else begin
               valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid     = valid_ff;
   assign value     = value_ff;
   assign value_nxt = value_in;

endmodule

### design/sliding_window_maximum.sv
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  request | req_valid/req_stall, sample, start     | in
//  result  | rsp_valid/rsp_stall, window_max        | out
//  csr     | csr_write_enable, csr_write_data       | in
//
// One item per cycle while req_stall is low: every cell compares against the
// new sample in parallel and the whole queue updates in the same edge; the
// result shows in the next cycle, from an output register. req_stall rises
// only while a result waits under rsp_stall. Synchronous reset empties the queue,
// zeroes the count and sets the window to one; no clearing pass is needed.
// Top level of the sliding window maximum; depends on swm_pkg and swm_cell.
module sliding_window_maximum #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   input  logic                               req_start_sequence,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_window_max,
   input  logic                               csr_write_enable,
   input  logic [swm_pkg::CSR_WIDTH-1:0]      csr_write_data
);

   localparam int AGE_W  = $clog2(WINDOW_MAX + 1) + 1;
   localparam int CMP_W  = (AGE_W > swm_pkg::CSR_WIDTH) ? AGE_W : swm_pkg::CSR_WIDTH;
   localparam int SEEN_W = $clog2(WINDOW_MAX + 1);

   logic [swm_pkg::CSR_WIDTH-1:0]  window_ff;
   logic [SEEN_W-1:0]              seen_ff, seen_in, seen_base;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_max_ff;

   logic                           accept;
   logic [CMP_W-1:0]               win_ext, win_lim, k_eff;
   logic                           front_valid, front_drop, emit;
   logic signed [SAMPLE_WIDTH-1:0] front_nxt;
   swm_pkg::ctrl_type              ctrl;

   logic                           keep    [0:WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] value   [0:WINDOW_MAX];
   logic [AGE_W-1:0]               age_inc [0:WINDOW_MAX];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Clamp the window to 1..WINDOW_MAX.
   assign win_ext = CMP_W'(window_ff);
   assign win_lim = CMP_W'(WINDOW_MAX);
   assign k_eff   = (window_ff == '0) ? CMP_W'(1) : ((win_ext > win_lim) ? win_lim : win_ext);

   // Drop the front if it has left the window, or if the queue would overflow.
   assign front_drop = front_valid & ~req_start_sequence & (CMP_W'(age_inc[0]) >= k_eff);

   assign ctrl.load  = accept;
   assign ctrl.clear = req_start_sequence;
   assign ctrl.shift = front_drop | keep[WINDOW_MAX-1];

   assign keep[WINDOW_MAX]    = 1'b0;
   assign value[WINDOW_MAX]   = '0;
   assign age_inc[WINDOW_MAX] = '0;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (AGE_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .head      (1'b1),
            .sample    (req_sample),
            .prv_keep  (1'b1),
            .nxt_keep  (keep[i+1]),
            .nxt_value (value[i+1]),
            .nxt_age   (age_inc[i+1]),
            .keep      (keep[i]),
            .valid     (front_valid),
            .value     (value[i]),
            .age_inc   (age_inc[i]),
            .value_nxt (front_nxt)
         );
      end else begin : g_body
         swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (AGE_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .head      (1'b0),
            .sample    (req_sample),
            .prv_keep  (keep[i-1]),
            .nxt_keep  (keep[i+1]),
            .nxt_value (value[i+1]),
            .nxt_age   (age_inc[i+1]),
            .keep      (keep[i]),
            .valid     (),
            .value     (value[i]),
            .age_inc   (age_inc[i]),
            .value_nxt ()
         );
      end
   end

   // Count samples of the current sequence, saturating at WINDOW_MAX.
   assign seen_base = req_start_sequence ? '0 : seen_ff;
   assign seen_in   = (seen_base < SEEN_W'(WINDOW_MAX)) ? seen_base + 1'b1 : seen_base;
   assign emit      = CMP_W'(seen_in) >= k_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swm_pkg::WINDOW_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         if (accept) begin
            seen_ff      <= seen_in;
            rsp_valid_ff <= emit;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_max_ff <= front_nxt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

endmodule

### design/swm_checker.sv
// Port-level checks for the sliding window maximum top level.
// Attached by the bind below; no package dependency.
module swm_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_window_max
);

   // A waiting item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_window_max))
      else $error("result changed while stalled");

   // Input must be held off while a result is stuck.
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stuck");

   // With nothing waiting the block never stalls its input.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // A fresh result follows an accepted item.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without an item");

endmodule

bind sliding_window_maximum swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_window_max (rsp_window_max)
);

### dv/sliding_window_maximum_test.sv
// Self-checking testbench for the sliding window maximum block.
// Predicts every window maximum from its own candidate queue and compares each result item.
// Depends on swm_pkg and the sliding_window_maximum RTL.
module sliding_window_maximum_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DEPTH        = 64;
   localparam int AGE_CEILING  = 16'hFFFF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 250;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_TOP    = 16'sh7FFF;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_BOTTOM = 16'sh8000;

   typedef enum int {
      SHAPE_SCATTER, SHAPE_FALLING, SHAPE_RISING, SHAPE_NARROW, SHAPE_EXTREME
   } shape_type;

   logic                             clock              = 1'b0;
   logic                             reset              = 1'b1;
   logic                             req_valid          = 1'b0;
   logic                             req_stall;
   logic signed [SAMPLE_WIDTH-1:0]   req_sample         = '0;
   logic                             req_start_sequence = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall          = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0]   rsp_window_max;
   logic                             csr_write_enable   = 1'b0;
   logic [swm_pkg::CSR_WIDTH-1:0]    csr_write_data     = '0;

   // predictor state
   logic signed [SAMPLE_WIDTH-1:0]   cand_values[$];
   int                               cand_ages[$];
   int                               samples_in_run = 0;
   int                               window_setting = swm_pkg::WINDOW_RESET;
   logic signed [SAMPLE_WIDTH-1:0]   expected_max_q[$];
   logic signed [SAMPLE_WIDTH-1:0]   oldest_max;

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   int   error_count   = 0;
   int   cycle_count   = 0;
   logic hold_active   = 1'b0;
   event hold_go;

   sliding_window_maximum #(
      .WINDOW_MAX  (DEPTH),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_start_sequence(req_start_sequence),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_max    (rsp_window_max),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // long receiver hold-off, counted here so the sender keeps offering meanwhile
   initial begin
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_max_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected window_max, expected none, actual %0d",
                     $time, rsp_window_max);
         end else begin
            oldest_max = expected_max_q[0];
            expected_max_q.delete(0);
            if (rsp_window_max !== oldest_max) begin
               error_count++;
               $display("%0t: window_max mismatch, expected %0d, actual %0d",
                        $time, oldest_max, rsp_window_max);
            end
         end
      end
      rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);
   end

   function automatic void predict_window_max(input logic signed [SAMPLE_WIDTH-1:0] value,
                                              input logic start);
      int k;
      if (start) begin
         cand_values.delete();
         cand_ages.delete();
         samples_in_run = 0;
      end
      k = (window_setting == 0) ? 1 : (window_setting > DEPTH) ? DEPTH : window_setting;
      foreach (cand_ages[i])
         if (cand_ages[i] < AGE_CEILING) cand_ages[i]++;
      // at most one stale entry leaves the front per item
      if (cand_values.size() > 0 && cand_ages[0] >= k) begin
         cand_values.delete(0);
         cand_ages.delete(0);
      end
      while (cand_values.size() > 0 && cand_values[$] <= value) begin
         cand_values.delete(cand_values.size() - 1);
         cand_ages.delete(cand_ages.size() - 1);
      end
      if (cand_values.size() >= DEPTH) begin
         cand_values.delete(0);
         cand_ages.delete(0);
      end
      cand_values.insert(cand_values.size(), value);
      cand_ages.insert(cand_ages.size(), 0);
      if (samples_in_run < DEPTH) samples_in_run++;
      if (samples_in_run >= k) expected_max_q.insert(expected_max_q.size(), cand_values[0]);
   endfunction

   task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] value, input logic start);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample         <= value;
      req_start_sequence <= start;
      do @(posedge clock); while (req_stall);
      predict_window_max(value, start);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_max_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [swm_pkg::CSR_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_setting = value;
   endtask

   // runs of items, each usually opening with a start flag, in one of several shapes
   task automatic send_runs(input int item_total, input int max_len, input logic fresh);
      int sent, len, shape, next, level;
      logic start;
      sent = 0;
      while (sent < item_total) begin
         len   = $urandom_range(1, max_len);
         if (len > item_total - sent) len = item_total - sent;
         shape = $urandom_range(SHAPE_SCATTER, SHAPE_EXTREME);
         level = $signed(16'($urandom));
         for (int i = 0; i < len; i++) begin
            case (shape)
               SHAPE_FALLING: begin
                  next  = level - $urandom_range(0, 900);
                  level = (next < -32768) ? -32768 : next;
               end
               SHAPE_RISING: begin
                  next  = level + $urandom_range(0, 900);
                  level = (next > 32767) ? 32767 : next;
               end
               SHAPE_NARROW:  level = $urandom_range(0, 6) - 3;
               SHAPE_EXTREME: level = $urandom_range(1) ? 32767 : -32768;
               default:       level = $signed(16'($urandom));
            endcase
            // mostly clean runs; now and then a stray start flag breaks one
            start = (i == 0) ? (fresh && $urandom_range(9) != 0) : ($urandom_range(79) == 0);
            send_item(16'(level), start);
         end
         sent += len;
      end
   endtask

   task automatic test_directed_extremes();
      send_item(SAMPLE_TOP, 1'b1);
      send_item(SAMPLE_BOTTOM, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(SAMPLE_TOP, 1'b1);
      send_item(SAMPLE_TOP, 1'b0);
      wait_drained();
   endtask

   task automatic test_zero_window();
      write_window(7'd0);
      send_item(16'sd5, 1'b1);
      send_item(SAMPLE_BOTTOM, 1'b0);
      send_item(16'sd1, 1'b0);
      wait_drained();
   endtask

   task automatic test_short_window();
      write_window(7'd3);
      send_item(16'sd5, 1'b1);
      send_item(16'sd5, 1'b0);
      send_item(16'sd2, 1'b0);
      send_item(16'sd9, 1'b0);
      send_item(-16'sd3, 1'b0);
      send_item(-16'sd3, 1'b0);
      send_item(-16'sd7, 1'b1);
      send_item(SAMPLE_BOTTOM, 1'b0);
      send_item(16'sd4, 1'b0);
      wait_drained();
   endtask

   // shrink and grow the window in the middle of a sequence
   task automatic test_window_change();
      write_window(7'd16);
      send_runs(30, 30, 1'b1);
      wait_drained();
      write_window(7'd2);
      send_runs(12, 12, 1'b0);
      wait_drained();
      write_window(7'd40);
      send_runs(50, 50, 1'b0);
      wait_drained();
   endtask

   // oversized window and long falling ramps keep the queue at its full depth
   task automatic test_full_queue();
      int level;
      write_window(7'd127);
      level = 32767;
      for (int i = 0; i < 90; i++) begin
         send_item(16'(level), i == 0);
         level -= $urandom_range(1, 300);
      end
      wait_drained();
      write_window(7'd64);
      for (int i = 0; i < 70; i++) begin
         send_item(16'(level), 1'b0);
         level -= $urandom_range(0, 200);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int k;
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = (mode == 1) ? 63 : (mode == 3) ? 37 : 0;
         stall_pct     = (mode == 2) ? 63 : (mode == 3) ? 37 : 0;
         for (int part = 0; part < 3; part++) begin
            case ($urandom_range(3))
               0:       k = 1;
               1:       k = 2;
               2:       k = 64;
               default: k = $urandom_range(0, 127);
            endcase
            write_window(7'(k));
            if (k == 0) k = 1;
            if (k > DEPTH) k = DEPTH;
            send_runs(120, 2 * k + 8, 1'b1);
            wait_drained();
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   task automatic test_backpressure();
      write_window(7'd4);
      -> hold_go;
      send_runs(120, 40, 1'b1);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_zero_window();
      test_short_window();
      test_window_change();
      test_full_queue();
      test_random_traffic();
      test_backpressure();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
